// ===== sv/pfc_pkg.sv =====
// Package for the palette fade and color cycling block.
// Holds the sizes, codes and transaction structs shared by every module.
// No dependencies.
package pfc_pkg;

  // Palette geometry.
  localparam int PALETTE_BYTES = 768;
  localparam int POS_W = $clog2(PALETTE_BYTES);
  localparam int COLORS = PALETTE_BYTES / 3;

  // Field widths fixed by the transaction format.
  localparam int CW = 6;
  localparam int IDX_FW = 10;
  localparam int COLOR_W = 8;

  // Component range and fade step.
  localparam logic [CW-1:0] CMAX = 6'h3f;
  localparam logic [CW-1:0] STEP = 6'd3;

  // Operation codes carried by an input transaction.
  typedef enum logic [2:0] {
    KIND_WR_TARGET = 3'd0,
    KIND_WR_LIVE   = 3'd1,
    KIND_FADE_IN   = 3'd2,
    KIND_FADE_OUT  = 3'd3,
    KIND_COPY      = 3'd4,
    KIND_ROTATE    = 3'd5,
    KIND_READ      = 3'd6,
    KIND_NOP       = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic                restart;
    logic [IDX_FW-1:0]   entry_index;
    logic [CW-1:0]       entry_value;
    logic [COLOR_W-1:0]  first_color;
    logic [COLOR_W-1:0]  last_color;
  } item_t;

  typedef struct packed {
    logic [CW-1:0] read_value;
    logic          fade_done;
    logic [CW-1:0] threshold_level;
    logic          rotate_ignored;
  } result_t;

  // One palette byte as it travels along the ring of cells.
  typedef struct packed {
    logic [CW-1:0] target;
    logic [CW-1:0] live;
  } entry_t;

  // What the head unit does to the byte passing it this cycle.
  typedef enum logic [2:0] {
    H_PASS,
    H_CLEAR,
    H_WR_TARGET,
    H_WR_LIVE,
    H_FADE_IN,
    H_FADE_OUT,
    H_COPY,
    H_ROTATE
  } head_mode_t;

  typedef struct packed {
    head_mode_t    mode;
    logic [CW-1:0] threshold;
    logic [CW-1:0] value;
  } head_ctrl_t;

endpackage

// ===== sv/pfc_cell.sv =====
// One storage cell of the palette ring: holds one target and one live byte.
// Hands its byte to the next cell every cycle. Depends on pfc_pkg.
module pfc_cell (
  input  logic            clk,
  input  pfc_pkg::entry_t d,
  output pfc_pkg::entry_t q
);

  // The ring shifts on every clock; no reset, the live bytes are cleared by a sweep.
  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

// ===== sv/pfc_head.sv =====
// Head unit of the palette ring: updates the byte leaving the last cell.
// Applies writes, fade steps, copy, clear and rotate data. Depends on pfc_pkg.
module pfc_head (
  input  pfc_pkg::entry_t     cur,
  input  pfc_pkg::head_ctrl_t ctrl,
  output pfc_pkg::entry_t     nxt
);

  logic [pfc_pkg::CW:0] raised;

  // Apply the selected operation to the passing byte.
  always_comb begin
    raised = {1'b0, cur.live} + {1'b0, pfc_pkg::STEP};
    nxt = cur;
    case (ctrl.mode)
      pfc_pkg::H_PASS: begin
        nxt = cur;
      end
      pfc_pkg::H_CLEAR: begin
        nxt.live = '0;
      end
      pfc_pkg::H_WR_TARGET: begin
        nxt.target = ctrl.value;
      end
      pfc_pkg::H_WR_LIVE: begin
        nxt.live = ctrl.value;
      end
      pfc_pkg::H_FADE_IN: begin
        // Raise toward the target; a live value above the target drops to it.
        if (cur.target >= ctrl.threshold) begin
          nxt.live = (raised < {1'b0, cur.target}) ? raised[pfc_pkg::CW-1:0] : cur.target;
        end
      end
      pfc_pkg::H_FADE_OUT: begin
        if (cur.target >= ctrl.threshold) begin
          nxt.live = (cur.live >= pfc_pkg::STEP) ? cur.live - pfc_pkg::STEP : '0;
        end
      end
      pfc_pkg::H_COPY: begin
        nxt.target = cur.live;
      end
      pfc_pkg::H_ROTATE: begin
        nxt.live = ctrl.value;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== sv/palette_fade_and_cycle.sv =====
// Palette fade and color cycling: a ring of PALETTE_BYTES cells that turns one step per cycle.
// Writes and reads wait for the byte to reach the head; fade and copy sweep one full turn of
// the ring; rotate finds the last color, keeps its three bytes and shifts the range from the
// first color. One transaction is in work at a time; the next is taken in the cycle after its
// result is loaded, which a held result delays. Reset: a clearing pass zeroes the live palette,
// threshold 63. Uses pfc_pkg, pfc_cell, pfc_head.
module palette_fade_and_cycle (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  pfc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output pfc_pkg::result_t result
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEEK,
    S_SWEEP,
    S_ROT_FIND_LAST,
    S_ROT_CAPTURE,
    S_ROT_FIND_FIRST,
    S_ROT_SHIFT,
    S_RESULT
  } state_t;

  localparam logic [pfc_pkg::POS_W-1:0] LAST = pfc_pkg::POS_W'(pfc_pkg::PALETTE_BYTES - 1);

  state_t                          state;
  logic [pfc_pkg::POS_W-1:0]       pos;
  logic [pfc_pkg::POS_W-1:0]       pos_next;
  logic [pfc_pkg::POS_W-1:0]       cnt;
  logic [pfc_pkg::CW-1:0]          thr;
  pfc_pkg::item_t                  itm;
  logic [pfc_pkg::IDX_FW-1:0]      a_first;
  logic [pfc_pkg::IDX_FW-1:0]      a_last;
  logic [pfc_pkg::IDX_FW-1:0]      a_end;
  logic [pfc_pkg::IDX_FW-1:0]      pos_ext;
  logic [pfc_pkg::CW-1:0]          dly [3];
  logic [pfc_pkg::CW-1:0]          rd;
  logic                            done;
  logic                            ign;
  logic                            idx_ok;
  logic                            rot_bad;
  logic                            hit_idx;
  pfc_pkg::head_ctrl_t             hc;
  pfc_pkg::entry_t                 head_out;
  pfc_pkg::entry_t                 tail;
  pfc_pkg::entry_t                 ring [pfc_pkg::PALETTE_BYTES];

  // Ring of cells; the head unit closes the loop from the last cell to the first.
  for (genvar g = 0; g < pfc_pkg::PALETTE_BYTES; g++) begin : g_ring
    if (g == 0) begin : g_first
      pfc_cell u_cell (.clk(clk), .d(head_out), .q(ring[g]));
    end else begin : g_rest
      pfc_cell u_cell (.clk(clk), .d(ring[g-1]), .q(ring[g]));
    end
  end

  assign tail = ring[pfc_pkg::PALETTE_BYTES-1];

  pfc_head u_head (.cur(tail), .ctrl(hc), .nxt(head_out));

  // Byte index at the head, compare helpers and input checks.
  assign pos_next = (pos == LAST) ? '0 : pos + 1'b1;
  assign pos_ext  = pfc_pkg::IDX_FW'(pos);
  assign hit_idx  = (pos_ext == itm.entry_index);
  assign a_end    = a_last + pfc_pkg::IDX_FW'(2);
  assign idx_ok   = item.entry_index < pfc_pkg::IDX_FW'(pfc_pkg::PALETTE_BYTES);
  assign rot_bad  = (item.first_color >= item.last_color) ||
                    (pfc_pkg::IDX_FW'(item.last_color) >= pfc_pkg::IDX_FW'(pfc_pkg::COLORS));
  assign item_stall = (state != S_IDLE);

  // Head control for the byte passing this cycle.
  always_comb begin
    hc.mode      = pfc_pkg::H_PASS;
    hc.threshold = thr;
    hc.value     = itm.entry_value;
    case (state)
      S_CLEAR: begin
        hc.mode = pfc_pkg::H_CLEAR;
      end
      S_SEEK: begin
        if (hit_idx && itm.kind == pfc_pkg::KIND_WR_TARGET) begin
          hc.mode = pfc_pkg::H_WR_TARGET;
        end else if (hit_idx && itm.kind == pfc_pkg::KIND_WR_LIVE) begin
          hc.mode = pfc_pkg::H_WR_LIVE;
        end
      end
      S_SWEEP: begin
        if (itm.kind == pfc_pkg::KIND_FADE_IN) begin
          hc.mode = pfc_pkg::H_FADE_IN;
        end else if (itm.kind == pfc_pkg::KIND_FADE_OUT) begin
          hc.mode = pfc_pkg::H_FADE_OUT;
        end else begin
          hc.mode = pfc_pkg::H_COPY;
        end
      end
      S_ROT_FIND_FIRST: begin
        if (pos_ext == a_first) begin
          hc.mode  = pfc_pkg::H_ROTATE;
          hc.value = dly[0];
        end
      end
      S_ROT_SHIFT: begin
        hc.mode  = pfc_pkg::H_ROTATE;
        hc.value = dly[0];
      end
      default: begin
        hc.mode = pfc_pkg::H_PASS;
      end
    endcase
  end

  // Sequencer: state, ring position, threshold and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      pos          <= '0;
      cnt          <= '0;
      thr          <= pfc_pkg::CMAX;
      result_valid <= 1'b0;
    end else begin
      pos <= pos_next;
      // The result state loads the next result itself when the current one is taken.
      if (result_valid && !result_stall && state != S_RESULT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            itm     <= item;
            rd      <= '0;
            done    <= 1'b0;
            ign     <= 1'b0;
            cnt     <= '0;
            a_first <= pfc_pkg::IDX_FW'({item.first_color, 1'b0}) +
                       pfc_pkg::IDX_FW'(item.first_color);
            a_last  <= pfc_pkg::IDX_FW'({item.last_color, 1'b0}) +
                       pfc_pkg::IDX_FW'(item.last_color);
            case (item.kind)
              pfc_pkg::KIND_WR_TARGET, pfc_pkg::KIND_WR_LIVE, pfc_pkg::KIND_READ: begin
                state <= idx_ok ? S_SEEK : S_RESULT;
              end
              pfc_pkg::KIND_FADE_IN: begin
                if (item.restart) begin
                  thr <= pfc_pkg::CMAX;
                end
                state <= S_SWEEP;
              end
              pfc_pkg::KIND_FADE_OUT: begin
                if (item.restart) begin
                  thr <= '0;
                end
                state <= S_SWEEP;
              end
              pfc_pkg::KIND_COPY: begin
                state <= S_SWEEP;
              end
              pfc_pkg::KIND_ROTATE: begin
                if (rot_bad) begin
                  ign   <= 1'b1;
                  state <= S_RESULT;
                end else begin
                  state <= S_ROT_FIND_LAST;
                end
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_SEEK: begin
          if (hit_idx) begin
            if (itm.kind == pfc_pkg::KIND_READ) begin
              rd <= tail.live;
            end
            state <= S_RESULT;
          end
        end
        S_SWEEP: begin
          // After a full turn, a fade steps the threshold toward the end of the fade; copy leaves it.
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_RESULT;
            if (itm.kind == pfc_pkg::KIND_FADE_IN) begin
              done <= (thr == '0);
              thr  <= (thr > pfc_pkg::STEP) ? thr - pfc_pkg::STEP : '0;
            end else if (itm.kind == pfc_pkg::KIND_FADE_OUT) begin
              done <= (thr == pfc_pkg::CMAX);
              thr  <= (thr >= pfc_pkg::CMAX - pfc_pkg::STEP) ? pfc_pkg::CMAX :
                      thr + pfc_pkg::STEP;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROT_FIND_LAST: begin
          // Keep the three bytes of the last color; they wrap to the first color.
          if (pos_ext == a_last) begin
            dly[0] <= dly[1];
            dly[1] <= dly[2];
            dly[2] <= tail.live;
            cnt    <= pfc_pkg::POS_W'(1);
            state  <= S_ROT_CAPTURE;
          end
        end
        S_ROT_CAPTURE: begin
          dly[0] <= dly[1];
          dly[1] <= dly[2];
          dly[2] <= tail.live;
          if (cnt == pfc_pkg::POS_W'(2)) begin
            cnt   <= '0;
            state <= S_ROT_FIND_FIRST;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROT_FIND_FIRST: begin
          if (pos_ext == a_first) begin
            dly[0] <= dly[1];
            dly[1] <= dly[2];
            dly[2] <= tail.live;
            state  <= S_ROT_SHIFT;
          end
        end
        S_ROT_SHIFT: begin
          // Each byte in the range is delayed by one color on its way round.
          dly[0] <= dly[1];
          dly[1] <= dly[2];
          dly[2] <= tail.live;
          if (pos_ext == a_end) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!result_valid || !result_stall) begin
            result.read_value      <= rd;
            result.fade_done       <= done;
            result.threshold_level <= thr;
            result.rotate_ignored  <= ign;
            result_valid           <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The head index walks the ring one byte per cycle.
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    pos != LAST |=> pos == $past(pos) + 1'b1)
    else $error("ring position skipped a byte");

  a_pos_wrap: assert property (@(posedge clk) disable iff (rst)
    pos == LAST |=> pos == '0)
    else $error("ring position failed to wrap");

  // Every accepted transaction leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state != S_IDLE)
    else $error("accepted transaction did not start work");

  // A new result only comes from the result state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_RESULT)
    else $error("result raised outside the result state");

  // No result appears while the live palette is being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !result_valid)
    else $error("result during clearing pass");

endmodule
